### design/mawd_pkg.sv
// shared types and constants for the motion activity window detector
`timescale 1ns / 1ps

package mawd_pkg;

  localparam int unsigned WIN_SIZE  = 32;
  localparam int unsigned WIN_AW    = $clog2(WIN_SIZE);
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned SUM_W     = MAG_W + WIN_AW;
  localparam int unsigned AXIS_W    = 13;
  localparam int unsigned SQSUM_W   = 26;
  localparam int unsigned ROOT_W    = 13;
  localparam int unsigned REM_W     = 14;
  localparam int unsigned SCALE_W   = 12;
  localparam int unsigned PROD_W    = ROOT_W + SCALE_W + 1;
  localparam int unsigned MAG_SHIFT = 10;
  localparam int unsigned CNT_W     = 5;

  localparam logic [SCALE_W-1:0] MAG_SCALE = 12'd3793;

  localparam logic [CNT_W-1:0] AXIS_LAST = 5'd2;
  localparam logic [CNT_W-1:0] ROOT_LAST = 5'd12;
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(WIN_SIZE - 1);

  // register indexes of the configuration port
  localparam logic [1:0] REG_AVG_HIGH  = 2'd0;
  localparam logic [1:0] REG_MAX_FLOOR = 2'd1;
  localparam logic [1:0] REG_MIN_CEIL  = 2'd2;
  localparam logic [1:0] REG_AVG_MID   = 2'd3;

  localparam logic [15:0] RST_AVG_HIGH  = 16'd2000;
  localparam logic [15:0] RST_MAX_FLOOR = 16'd2;
  localparam logic [15:0] RST_MIN_CEIL  = 16'd500;
  localparam logic [15:0] RST_AVG_MID   = 16'd1200;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_SCALE,
    ST_UPDATE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             load_in;
    logic             sq_step;
    logic             root_step;
    logic             scale;
    logic             update;
    logic             rd_scan;
    logic             scan_cmp;
    logic             scan_first;
    logic             out_load;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [15:0] avg_high;
    logic [15:0] max_floor;
    logic [15:0] min_ceil;
    logic [15:0] avg_mid;
  } cfg_t;

endpackage

### design/mawd_ctrl.sv
// sequencing state machine for the motion activity window detector
`timescale 1ns / 1ps

module mawd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  mawd_pkg::stat_t stat_i,
  output mawd_pkg::cmd_t  cmd_o
);

  mawd_pkg::state_e             state_q, state_d;
  logic [mawd_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mawd_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    cmd_o.idx = cnt_q;
    case (state_q)
      mawd_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d         = '0;
          state_d       = mawd_pkg::ST_SQUARE;
        end
      end
      mawd_pkg::ST_SQUARE: begin
        cmd_o.sq_step = 1'b1;
        if (cnt_q == mawd_pkg::AXIS_LAST) begin
          cnt_d   = '0;
          state_d = mawd_pkg::ST_ROOT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      mawd_pkg::ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == mawd_pkg::ROOT_LAST) begin
          cnt_d   = '0;
          state_d = mawd_pkg::ST_SCALE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      mawd_pkg::ST_SCALE: begin
        // old entry at the write pointer is read in this cycle too
        cmd_o.scale = 1'b1;
        state_d     = mawd_pkg::ST_UPDATE;
      end
      mawd_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        cnt_d        = '0;
        state_d      = mawd_pkg::ST_SCAN;
      end
      mawd_pkg::ST_SCAN: begin
        // read data is registered, so it arrives in the cycle after its address
        cmd_o.rd_scan    = 1'b1;
        cmd_o.scan_cmp   = (cnt_q != '0);
        cmd_o.scan_first = (cnt_q == {{(mawd_pkg::CNT_W-1){1'b0}}, 1'b1});
        if (cnt_q == mawd_pkg::SCAN_LAST) begin
          state_d = mawd_pkg::ST_SCAN_END;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      mawd_pkg::ST_SCAN_END: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = mawd_pkg::ST_DONE;
      end
      mawd_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = mawd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mawd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### design/mawd_dp.sv
// datapath: squares, shared root unit, window ring, min/max scan and output register
`timescale 1ns / 1ps

module mawd_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mawd_pkg::cmd_t                    cmd_i,
  output mawd_pkg::stat_t                   stat_o,
  input  mawd_pkg::cfg_t                    cfg_i,
  input  logic signed [mawd_pkg::AXIS_W-1:0] accel_x_i,
  input  logic signed [mawd_pkg::AXIS_W-1:0] accel_y_i,
  input  logic signed [mawd_pkg::AXIS_W-1:0] accel_z_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [mawd_pkg::MAG_W-1:0]        magnitude_o,
  output logic [mawd_pkg::MAG_W-1:0]        window_min_o,
  output logic [mawd_pkg::MAG_W-1:0]        window_max_o,
  output logic [mawd_pkg::MAG_W-1:0]        window_mean_o,
  output logic                              active_o
);

  localparam int unsigned MW = mawd_pkg::MAG_W;

  logic signed [mawd_pkg::AXIS_W-1:0]  x_q, y_q, z_q;
  logic signed [mawd_pkg::AXIS_W-1:0]  axis_sel;
  logic signed [mawd_pkg::SQSUM_W-1:0] sq;
  logic [mawd_pkg::SQSUM_W-1:0]        acc_q;

  logic [mawd_pkg::SQSUM_W-1:0] rad_q, rad_src;
  logic [mawd_pkg::REM_W-1:0]   rem_q, rem_src;
  logic [mawd_pkg::ROOT_W-1:0]  root_q, root_src;
  logic [mawd_pkg::REM_W+1:0]   rem_t, trial, rem_diff;
  logic                         root_bit;

  logic [mawd_pkg::PROD_W-1:0]  prod;
  logic [MW-1:0]                mag_q;

  logic [MW-1:0]                mem_q [mawd_pkg::WIN_SIZE];
  logic [mawd_pkg::WIN_SIZE-1:0] vld_q;
  logic [mawd_pkg::WIN_AW-1:0]  wp_q, rd_addr;
  logic [MW-1:0]                rd_data_q, rd_val;
  logic                         rd_vld_q;

  logic [mawd_pkg::SUM_W-1:0]   sum_q;
  logic [MW-1:0]                min_q, max_q, mean;
  logic                         out_vld_q, act;

  // one axis squared per cycle
  always_comb begin
    case (cmd_i.idx[1:0])
      2'd0:    axis_sel = x_q;
      2'd1:    axis_sel = y_q;
      default: axis_sel = z_q;
    endcase
  end
  assign sq = axis_sel * axis_sel;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q   <= accel_x_i;
      y_q   <= accel_y_i;
      z_q   <= accel_z_i;
      acc_q <= '0;
    end else if (cmd_i.sq_step) begin
      acc_q <= acc_q + $unsigned(sq);
    end
  end

  // restoring square root, two radicand bits per step
  always_comb begin
    if (cmd_i.idx == '0) begin
      rad_src  = acc_q;
      rem_src  = '0;
      root_src = '0;
    end else begin
      rad_src  = rad_q;
      rem_src  = rem_q;
      root_src = root_q;
    end
    rem_t    = {rem_src, rad_src[mawd_pkg::SQSUM_W-1 -: 2]};
    trial    = {1'b0, root_src, 2'b01};
    rem_diff = rem_t - trial;
    root_bit = (rem_t >= trial);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_step) begin
      rad_q  <= {rad_src[mawd_pkg::SQSUM_W-3:0], 2'b00};
      rem_q  <= root_bit ? rem_diff[mawd_pkg::REM_W-1:0] : rem_t[mawd_pkg::REM_W-1:0];
      root_q <= {root_src[mawd_pkg::ROOT_W-2:0], root_bit};
    end
  end

  assign prod = {1'b0, root_q} * {1'b0, mawd_pkg::MAG_SCALE};

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      mag_q <= prod[mawd_pkg::MAG_SHIFT +: MW];
    end
  end

  // window ring
  assign rd_addr = cmd_i.rd_scan ? cmd_i.idx[mawd_pkg::WIN_AW-1:0] : wp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      mem_q[wp_q] <= mag_q;
    end
    rd_data_q <= mem_q[rd_addr];
    rd_vld_q  <= vld_q[rd_addr];
  end

  // never-written entries read as zero
  assign rd_val = rd_vld_q ? rd_data_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      wp_q  <= '0;
      sum_q <= '0;
    end else if (cmd_i.update) begin
      vld_q[wp_q] <= 1'b1;
      sum_q       <= sum_q - {{mawd_pkg::WIN_AW{1'b0}}, rd_val}
                           + {{mawd_pkg::WIN_AW{1'b0}}, mag_q};
      if (wp_q == mawd_pkg::WIN_AW'(mawd_pkg::WIN_SIZE - 1)) begin
        wp_q <= '0;
      end else begin
        wp_q <= wp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_cmp) begin
      if (cmd_i.scan_first || rd_val < min_q) begin
        min_q <= rd_val;
      end
      if (cmd_i.scan_first || rd_val > max_q) begin
        max_q <= rd_val;
      end
    end
  end

  assign mean = sum_q[mawd_pkg::WIN_AW +: MW];
  assign act  = (mean > cfg_i.avg_high) ||
                ((max_q > cfg_i.max_floor) && (min_q < cfg_i.min_ceil) &&
                 (mean > cfg_i.avg_mid));

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      magnitude_o   <= mag_q;
      window_min_o  <= min_q;
      window_max_o  <= max_q;
      window_mean_o <= mean;
      active_o      <= act;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign stat_o.out_free = !out_vld_q || out_ready_i;

endmodule

### design/motion_activity_window_detector_top.sv
// top level of the motion activity window detector: ports, config registers, wiring
//
//  channel   direction  payload
//  s_axis    in         tdata: accel_x[12:0], accel_y[25:13], accel_z[38:26], zero pad
//  m_axis    out        tdata: magnitude, window_min, window_max, window_mean; tuser: active
//  apb       in/out     four 16-bit threshold registers at byte addresses 0, 4, 8, 12
//
//  a sample goes through the squares, the root unit (two bits a step), the scale, the ring
//  update, the min/max scan over the window memory, which has one read port, and the
//  load of the output register; a new sample is taken only when the sequencer is back in
//  idle, so the block is through with one sample before it takes the next. reset
//  empties the ring through per-entry valid bits and loads the threshold defaults.
//  a stalled result holds the sequencer in its last state.
`timescale 1ns / 1ps

module motion_activity_window_detector_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // accel_x, accel_y, accel_z, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // magnitude, window_min, window_max, window_mean
  output logic [0:0]  m_axis_tuser,  // active
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mawd_pkg::cmd_t  cmd;
  mawd_pkg::stat_t stat;
  mawd_pkg::cfg_t  cfg_q;
  logic            cfg_wr;
  logic [15:0]     mag, wmin, wmax, wmean;
  logic            act;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.avg_high  <= mawd_pkg::RST_AVG_HIGH;
      cfg_q.max_floor <= mawd_pkg::RST_MAX_FLOOR;
      cfg_q.min_ceil  <= mawd_pkg::RST_MIN_CEIL;
      cfg_q.avg_mid   <= mawd_pkg::RST_AVG_MID;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mawd_pkg::REG_AVG_HIGH:  cfg_q.avg_high  <= pwdata[15:0];
        mawd_pkg::REG_MAX_FLOOR: cfg_q.max_floor <= pwdata[15:0];
        mawd_pkg::REG_MIN_CEIL:  cfg_q.min_ceil  <= pwdata[15:0];
        mawd_pkg::REG_AVG_MID:   cfg_q.avg_mid   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mawd_pkg::REG_AVG_HIGH:  prdata = {16'd0, cfg_q.avg_high};
      mawd_pkg::REG_MAX_FLOOR: prdata = {16'd0, cfg_q.max_floor};
      mawd_pkg::REG_MIN_CEIL:  prdata = {16'd0, cfg_q.min_ceil};
      mawd_pkg::REG_AVG_MID:   prdata = {16'd0, cfg_q.avg_mid};
      default:                 prdata = '0;
    endcase
  end

  mawd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  mawd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_i         (cfg_q),
    .accel_x_i     (s_axis_tdata[12:0]),
    .accel_y_i     (s_axis_tdata[25:13]),
    .accel_z_i     (s_axis_tdata[38:26]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .magnitude_o   (mag),
    .window_min_o  (wmin),
    .window_max_o  (wmax),
    .window_mean_o (wmean),
    .active_o      (act)
  );

  assign m_axis_tdata = {wmean, wmax, wmin, mag};
  assign m_axis_tuser = act;

endmodule

### design/mawd_checker.sv
// port-level checks for the motion activity window detector, bound to the top level
`timescale 1ns / 1ps

module mawd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // a result waiting for its request to be taken stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // the new magnitude is itself in the window
  a_mag_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:16] <= m_axis_tdata[15:0]) &&
                      (m_axis_tdata[15:0] <= m_axis_tdata[47:32]))
    else $error("magnitude outside window min/max");

  // one sample at a time through the sequencer
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second sample taken while busy");

endmodule

bind motion_activity_window_detector_top mawd_checker u_mawd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/motion_activity_window_detector_top_tb.sv
// self-checking testbench for the motion activity window detector top level
`timescale 1ns / 1ps

module motion_activity_window_detector_top_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_REQUESTS = 80;
  localparam int RANDOM_PHASES = 8;

  typedef struct {
    logic signed [mawd_pkg::AXIS_W-1:0] x;
    logic signed [mawd_pkg::AXIS_W-1:0] y;
    logic signed [mawd_pkg::AXIS_W-1:0] z;
  } accel_sample_t;

  typedef struct {
    logic [mawd_pkg::MAG_W-1:0] magnitude;
    logic [mawd_pkg::MAG_W-1:0] window_min;
    logic [mawd_pkg::MAG_W-1:0] window_max;
    logic [mawd_pkg::MAG_W-1:0] window_mean;
    logic                       active;
  } activity_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // accel_x, accel_y, accel_z, pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // magnitude, window_min, window_max, window_mean
  logic [0:0]  m_axis_tuser;       // active
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // sample requests waiting for the driver, and results owed by the block
  accel_sample_t    sample_requests[$];
  activity_result_t results_owed[$];

  // shadow of the detector: magnitude ring, running sum and thresholds
  logic [mawd_pkg::MAG_W-1:0] mag_ring [mawd_pkg::WIN_SIZE] = '{default: '0};
  int unsigned      ring_wr = 0;
  logic [31:0]      ring_sum = '0;
  mawd_pkg::cfg_t   thresholds = '{avg_high: mawd_pkg::RST_AVG_HIGH,
                                   max_floor: mawd_pkg::RST_MAX_FLOOR,
                                   min_ceil: mawd_pkg::RST_MIN_CEIL,
                                   avg_mid: mawd_pkg::RST_AVG_MID};

  int          send_gap_max = 0;
  int          take_stall_max = 0;
  int          send_gap = 0;
  int          take_stall = 0;
  int          hold_left = 0;
  int          samples_sent = 0;
  int          results_checked = 0;
  int          active_seen = 0;
  int          mismatches = 0;
  int          settings_used = 1;
  int unsigned cycle_count = 0;
  accel_sample_t in_flight;

  motion_activity_window_detector_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] floor_root(input logic [31:0] radicand);
    logic [31:0] rest;
    logic [31:0] root;
    logic [31:0] bitv;
    rest = radicand;
    root = '0;
    bitv = 32'h4000_0000;
    while (bitv > rest) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rest >= root + bitv) begin
        rest = rest - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // advances the shadow ring by one sample and returns the result it owes
  function automatic activity_result_t predict_activity(input accel_sample_t s);
    activity_result_t           r;
    int                         xi;
    int                         yi;
    int                         zi;
    logic [31:0]                energy;
    logic [31:0]                scaled;
    logic [31:0]                mean;
    logic [mawd_pkg::MAG_W-1:0] lo;
    logic [mawd_pkg::MAG_W-1:0] hi;
    xi = s.x;
    yi = s.y;
    zi = s.z;
    energy = xi * xi + yi * yi + zi * zi;
    scaled = (floor_root(energy) * 32'(mawd_pkg::MAG_SCALE)) >> mawd_pkg::MAG_SHIFT;
    if (scaled > 32'hFFFF) scaled = 32'hFFFF;
    ring_sum = ring_sum - mag_ring[ring_wr] + scaled;
    mag_ring[ring_wr] = scaled[mawd_pkg::MAG_W-1:0];
    ring_wr = (ring_wr == mawd_pkg::WIN_SIZE - 1) ? 0 : ring_wr + 1;
    lo = mag_ring[0];
    hi = mag_ring[0];
    for (int i = 1; i < mawd_pkg::WIN_SIZE; i++) begin
      if (mag_ring[i] > hi) hi = mag_ring[i];
      if (mag_ring[i] < lo) lo = mag_ring[i];
    end
    mean = ring_sum / mawd_pkg::WIN_SIZE;
    if (mean > 32'hFFFF) mean = 32'hFFFF;
    r.magnitude = scaled[mawd_pkg::MAG_W-1:0];
    r.window_min = lo;
    r.window_max = hi;
    r.window_mean = mean[mawd_pkg::MAG_W-1:0];
    r.active = (mean > thresholds.avg_high) ||
               ((hi > thresholds.max_floor) && (lo < thresholds.min_ceil) &&
                (mean > thresholds.avg_mid));
    return r;
  endfunction

  task automatic check_field(input string field, input logic [mawd_pkg::MAG_W-1:0] want,
                             input logic [mawd_pkg::MAG_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // sender: next request goes out once the previous one is taken and its gap has run
  always @(posedge clk_i or negedge rst_ni) begin
    logic        offer;
    logic [39:0] word;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = s_axis_tvalid;
      word = s_axis_tdata;
      if (s_axis_tvalid && s_axis_tready) begin
        results_owed.push_back(predict_activity(in_flight));
        samples_sent++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_requests.size() > 0) begin
          in_flight = sample_requests.pop_front();
          offer = 1'b1;
          word = {1'b0, in_flight.z, in_flight.y, in_flight.x};
          send_gap = $urandom_range(0, send_gap_max);
        end
      end
      s_axis_tvalid <= offer;
      s_axis_tdata <= word;
    end
  end

  // receiver: checks each result and stalls between them
  always @(posedge clk_i or negedge rst_ni) begin
    activity_result_t want;
    logic             take;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      take_stall = 0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_owed.size() == 0) begin
          $error("result with nothing expected: magnitude %0d", m_axis_tdata[15:0]);
          mismatches++;
        end else begin
          want = results_owed.pop_front();
          check_field("magnitude", want.magnitude, m_axis_tdata[15:0]);
          check_field("window_min", want.window_min, m_axis_tdata[31:16]);
          check_field("window_max", want.window_max, m_axis_tdata[47:32]);
          check_field("window_mean", want.window_mean, m_axis_tdata[63:48]);
          check_field("active", 16'(want.active), 16'(m_axis_tuser[0]));
        end
        results_checked++;
        if (m_axis_tuser[0]) active_seen++;
        take_stall = $urandom_range(0, take_stall_max);
        // one long back-pressure spell so the block fills and refuses input
        if (results_checked == 200) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (take_stall > 0) begin
        take_stall--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      m_axis_tready <= take;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               results_owed.size());
      $display("motion_activity_window_detector_top_tb: FAIL");
      $finish;
    end
  end

  task automatic write_threshold(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      mawd_pkg::REG_AVG_HIGH:  thresholds.avg_high = value;
      mawd_pkg::REG_MAX_FLOOR: thresholds.max_floor = value;
      mawd_pkg::REG_MIN_CEIL:  thresholds.min_ceil = value;
      mawd_pkg::REG_AVG_MID:   thresholds.avg_mid = value;
      default: ;
    endcase
  endtask

  task automatic push_sample(input int x, input int y, input int z);
    accel_sample_t s;
    s.x = mawd_pkg::AXIS_W'(x);
    s.y = mawd_pkg::AXIS_W'(y);
    s.z = mawd_pkg::AXIS_W'(z);
    sample_requests.push_back(s);
  endtask

  function automatic logic signed [mawd_pkg::AXIS_W-1:0] pick_axis(input int kind);
    int v;
    if (kind <= 3) begin
      v = int'($urandom_range(0, 800)) - 400;
    end else if (kind <= 5) begin
      v = int'($urandom_range(0, 3000)) - 1500;
    end else if (kind <= 8) begin
      v = int'($urandom_range(0, 8191)) - 4096;
    end else begin
      case ($urandom_range(0, 3))
        0: v = -4096;
        1: v = 4095;
        2: v = 0;
        default: v = -1;
      endcase
    end
    return mawd_pkg::AXIS_W'(v);
  endfunction

  // runs of one motion style, so windows settle at rest, in motion and in between
  task automatic queue_motion(input int count);
    int            left;
    int            run;
    int            kind;
    accel_sample_t s;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      run = $urandom_range(4, 40);
      if (run > left) run = left;
      repeat (run) begin
        s.x = pick_axis(kind);
        s.y = pick_axis(kind);
        s.z = pick_axis(kind);
        sample_requests.push_back(s);
      end
      left -= run;
    end
  endtask

  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (sample_requests.size() != 0 || s_axis_tvalid || results_owed.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed requests under the reset thresholds; the ring starts empty
    send_gap_max = 17;
    take_stall_max = 17;
    @(negedge clk_i);
    push_sample(0, 0, 0);
    push_sample(4095, 4095, 4095);
    push_sample(-4096, -4096, -4096);
    push_sample(-4096, 0, 0);
    push_sample(0, 4095, 0);
    push_sample(0, 0, -4096);
    push_sample(-1, -1, -1);
    push_sample(1, 0, 0);
    push_sample(270, 0, 0);
    push_sample(0, -270, 0);
    push_sample(3, 4, 0);
    push_sample(-4096, 4095, -4096);
    push_sample(4095, -4096, 4095);
    push_sample(2048, 2048, 2048);
    push_sample(-2048, 1024, -512);
    push_sample(0, 0, 1);
    push_sample(100, 100, 100);
    push_sample(2700, 0, 0);
    push_sample(-2700, 0, 0);
    push_sample(0, 0, 2700);
    push_sample(2730, -2731, 2730);
    push_sample(-4095, -4095, 0);
    push_sample(5, 5, 5);
    wait_for_drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          write_threshold(mawd_pkg::REG_AVG_HIGH, 16'd0);
          write_threshold(mawd_pkg::REG_MAX_FLOOR, 16'd0);
          write_threshold(mawd_pkg::REG_MIN_CEIL, 16'd0);
          write_threshold(mawd_pkg::REG_AVG_MID, 16'd0);
        end
        1: begin
          write_threshold(mawd_pkg::REG_AVG_HIGH, 16'hFFFF);
          write_threshold(mawd_pkg::REG_MAX_FLOOR, 16'hFFFF);
          write_threshold(mawd_pkg::REG_MIN_CEIL, 16'hFFFF);
          write_threshold(mawd_pkg::REG_AVG_MID, 16'hFFFF);
        end
        2: begin
          write_threshold(mawd_pkg::REG_AVG_HIGH, mawd_pkg::RST_AVG_HIGH);
          write_threshold(mawd_pkg::REG_MAX_FLOOR, mawd_pkg::RST_MAX_FLOOR);
          write_threshold(mawd_pkg::REG_MIN_CEIL, mawd_pkg::RST_MIN_CEIL);
          write_threshold(mawd_pkg::REG_AVG_MID, mawd_pkg::RST_AVG_MID);
        end
        default: begin
          write_threshold(mawd_pkg::REG_AVG_HIGH, 16'($urandom_range(1000, 20000)));
          write_threshold(mawd_pkg::REG_MAX_FLOOR, 16'($urandom_range(0, 20000)));
          write_threshold(mawd_pkg::REG_MIN_CEIL, 16'($urandom_range(0, 3000)));
          write_threshold(mawd_pkg::REG_AVG_MID, 16'($urandom_range(0, 8000)));
        end
      endcase
      settings_used++;
      send_gap_max = p[0] ? 17 : 0;
      take_stall_max = p[1] ? 17 : 0;
      @(negedge clk_i);
      queue_motion(PHASE_REQUESTS);
      wait_for_drain();
    end

    repeat (60) @(negedge clk_i);
    if (results_owed.size() != 0) begin
      $error("%0d results never arrived", results_owed.size());
      mismatches++;
    end
    $display("sent %0d samples, checked %0d results over %0d threshold settings",
             samples_sent, results_checked, settings_used);
    $display("activity flagged on %0d results, %0d mismatches", active_seen, mismatches);
    if (mismatches == 0) begin
      $display("motion_activity_window_detector_top_tb: PASS");
    end else begin
      $display("motion_activity_window_detector_top_tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/mawd_pkg.sv
design/mawd_ctrl.sv
design/mawd_dp.sv
design/motion_activity_window_detector_top.sv
design/mawd_checker.sv
tb/motion_activity_window_detector_top_tb.sv
